// ===== hdl/rgb_to_hsl_pixel_macros.svh =====
// Assertion macros for the RGB to HSL pixel converter.
`ifndef RGB_TO_HSL_PIXEL_MACROS_SVH
`define RGB_TO_HSL_PIXEL_MACROS_SVH
`ifndef SYNTH
`define RTH_ASSERT_IMPLY(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |-> (b)) \
        else $error("assertion failed");
`define RTH_ASSERT_NEXT(lbl, a, b) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`else
`define RTH_ASSERT_IMPLY(lbl, a, b)
`define RTH_ASSERT_NEXT(lbl, a, b)
`endif
`endif

// ===== hdl/rth_pkg.sv =====
// Shared constants and types of the RGB to HSL converter.
`timescale 1ns / 1ps
package rth_pkg;
    localparam int CB = 8;                 // channel bits
    localparam int FW = 8;                 // output field width
    localparam int NW = 2 * CB + 4;        // dividend width
    localparam int DW = CB + 4;            // divisor width
    localparam int HW = CB + 3;            // hue numerator width
    localparam logic [CB-1:0] M = {CB{1'b1}};

    typedef enum logic [1:0] {
        SEL_RED   = 2'd0,
        SEL_GREEN = 2'd1,
        SEL_BLUE  = 2'd2
    } t_sel;

    typedef struct packed {
        logic [FW-1:0] alpha;
        logic [CB-1:0] lig;
        logic          grey;
    } t_side;

    typedef struct packed {
        logic [NW-1:0] hue_num;
        logic [DW-1:0] hue_den;
        logic [NW-1:0] sat_num;
        logic [DW-1:0] sat_den;
    } t_divin;
endpackage

// ===== hdl/rgb_to_hsl_pixel.sv =====
// RGB to HSL pixel converter, top level.
// Path: an accepted input passes the rth_stats front stages, then the divider stages, to output valid.
// Throughput: one item per clock; the pipeline advances whenever the output
//   register is empty or being taken, so a stall holds every stage in place.
// Reset: synchronous active-low i_rst_n clears all valid bits; data regs keep
//   their contents.
`timescale 1ns / 1ps
`include "rgb_to_hsl_pixel_macros.svh"
module rgb_to_hsl_pixel (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [7:0] red_in, [15:8] green_in, [23:16] blue_in, [31:24] alpha_in
    input  logic [31:0] i_s_axis_tdata,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] hue_out, [15:8] saturation_out, [23:16] lightness_out, [31:24] alpha_out
    output logic [31:0] o_m_axis_tdata
);
    localparam int CB = rth_pkg::CB;
    localparam int FW = rth_pkg::FW;

    logic            w_en;
    logic            w_st_vld;
    rth_pkg::t_side  w_st_side;
    rth_pkg::t_divin w_st_div;
    logic [CB-1:0]   w_hue_q, w_sat_q;

    // Sideband travels beside the divider stages.
    logic [CB-1:0]   r_vld;
    rth_pkg::t_side  r_side [CB];

    // Advance the whole pipe when the output slot is free or being drained.
    assign w_en = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    rth_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_s_axis_tvalid),
        .i_red   (i_s_axis_tdata[7:0]),
        .i_green (i_s_axis_tdata[15:8]),
        .i_blue  (i_s_axis_tdata[23:16]),
        .i_alpha (i_s_axis_tdata[31:24]),
        .o_valid (w_st_vld),
        .o_side  (w_st_side),
        .o_div   (w_st_div)
    );

    // Hue: (2hM + 6d) / 12d.
    rth_div u_div_hue (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_st_div.hue_num),
        .i_den (w_st_div.hue_den),
        .o_quo (w_hue_q)
    );

    // Saturation: (2dM + sden) / 2sden.
    rth_div u_div_sat (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_st_div.sat_num),
        .i_den (w_st_div.sat_den),
        .o_quo (w_sat_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[CB-2:0], w_st_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= w_st_side;
            for (int i = 1; i < CB; i++) begin
                r_side[i] <= r_side[i-1];
            end
        end
    end

    // Force hue and saturation to zero for grey pixels, whose hue divisor is zero.
    assign o_m_axis_tvalid = r_vld[CB-1];
    assign o_m_axis_tdata = {
        r_side[CB-1].alpha,
        FW'(r_side[CB-1].lig),
        r_side[CB-1].grey ? {FW{1'b0}} : FW'(w_sat_q),
        r_side[CB-1].grey ? {FW{1'b0}} : FW'(w_hue_q)
    };

    // A colored pixel never rounds saturation to zero, so nonzero hue implies it.
    `RTH_ASSERT_IMPLY(a_hue_sat, o_m_axis_tvalid && |o_m_axis_tdata[7:0], |o_m_axis_tdata[15:8])
    // A result still waiting stays valid.
    `RTH_ASSERT_NEXT(a_out_held, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid)
    // A held result blocks the input side.
    `RTH_ASSERT_IMPLY(a_no_accept_on_stall, o_m_axis_tvalid && !i_m_axis_tready, !o_s_axis_tready)
endmodule

// ===== hdl/rth_stats.sv =====
// Front stages: max/min, hue and saturation terms, divider operands.
`timescale 1ns / 1ps
module rth_stats (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [rth_pkg::FW-1:0] i_red,
    input  logic [rth_pkg::FW-1:0] i_green,
    input  logic [rth_pkg::FW-1:0] i_blue,
    input  logic [rth_pkg::FW-1:0] i_alpha,
    output logic                   o_valid,
    output rth_pkg::t_side         o_side,
    output rth_pkg::t_divin        o_div
);
    localparam int CB = rth_pkg::CB;
    localparam int HW = rth_pkg::HW;
    localparam int NW = rth_pkg::NW;
    localparam int DW = rth_pkg::DW;

    logic [CB-1:0] w_r, w_g, w_b, w_mx, w_mn;
    rth_pkg::t_sel w_sel;

    // stage 1
    logic [2:0]            r_vld;
    logic [CB-1:0]         r1_r, r1_g, r1_b, r1_mx, r1_mn;
    rth_pkg::t_sel         r1_sel;
    logic [rth_pkg::FW-1:0] r1_a;
    // stage 2
    logic [CB-1:0]         n_d;
    logic [CB:0]           n_s, n_sden;
    logic [HW-1:0]         n_h;
    logic [CB-1:0]         r2_d;
    logic [CB:0]           r2_sden;
    logic [HW-1:0]         r2_h;
    rth_pkg::t_side        r2_side;
    // stage 3
    rth_pkg::t_divin       n_div;
    rth_pkg::t_divin       r3_div;
    rth_pkg::t_side        r3_side;

    always_comb begin
        w_r = CB'(i_red);
        w_g = CB'(i_green);
        w_b = CB'(i_blue);
        w_mx = w_r;
        w_mn = w_r;
        w_sel = rth_pkg::SEL_RED;
        if (w_g > w_mx) begin
            w_mx = w_g;
            w_sel = rth_pkg::SEL_GREEN;
        end
        if (w_b > w_mx) begin
            w_mx = w_b;
            w_sel = rth_pkg::SEL_BLUE;
        end
        if (w_g < w_mn) w_mn = w_g;
        if (w_b < w_mn) w_mn = w_b;
    end

    always_comb begin
        n_d = r1_mx - r1_mn;
        n_s = {1'b0, r1_mx} + {1'b0, r1_mn};
        n_sden = (n_s < {1'b0, rth_pkg::M}) ? n_s : ({rth_pkg::M, 1'b0} - n_s);
        case (r1_sel)
            rth_pkg::SEL_RED: begin
                if (r1_g >= r1_b) n_h = HW'(r1_g) - HW'(r1_b);
                else n_h = HW'(6) * HW'(n_d) - (HW'(r1_b) - HW'(r1_g));
            end
            rth_pkg::SEL_GREEN: n_h = (HW'(n_d) << 1) + HW'(r1_b) - HW'(r1_r);
            default: n_h = (HW'(n_d) << 2) + HW'(r1_r) - HW'(r1_g);
        endcase
    end

    // Rounded quotient floor(N/D + 1/2) as floor((2N + D) / 2D).
    always_comb begin
        n_div.hue_num = (NW'(r2_h) << (CB + 1)) - (NW'(r2_h) << 1)
                        + NW'(6) * NW'(r2_d);
        n_div.hue_den = DW'(12) * DW'(r2_d);
        n_div.sat_num = (NW'(r2_d) << (CB + 1)) - (NW'(r2_d) << 1) + NW'(r2_sden);
        n_div.sat_den = DW'(r2_sden) << 1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[1:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_r <= w_r;
            r1_g <= w_g;
            r1_b <= w_b;
            r1_mx <= w_mx;
            r1_mn <= w_mn;
            r1_sel <= w_sel;
            r1_a <= i_alpha;
            r2_d <= n_d;
            r2_sden <= n_sden;
            r2_h <= n_h;
            r2_side.alpha <= r1_a;
            r2_side.lig <= CB'((n_s + (CB+1)'(1)) >> 1);
            r2_side.grey <= (n_d == '0);
            r3_div <= n_div;
            r3_side <= r2_side;
        end
    end

    assign o_valid = r_vld[2];
    assign o_side  = r3_side;
    assign o_div   = r3_div;
endmodule

// ===== hdl/rth_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module rth_div (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic [rth_pkg::NW-1:0] i_num,
    input  logic [rth_pkg::DW-1:0] i_den,
    output logic [rth_pkg::CB-1:0] o_quo
);
    localparam int CB = rth_pkg::CB;
    localparam int NW = rth_pkg::NW;
    localparam int DW = rth_pkg::DW;

    logic [NW-1:0] r_rem [CB];
    logic [DW-1:0] r_den [CB];
    logic [CB-1:0] r_q   [CB];
    logic [NW-1:0] w_rem [CB];
    logic [DW-1:0] w_den [CB];
    logic [CB-1:0] w_q   [CB];
    logic [NW-1:0] n_rem [CB];
    logic [CB-1:0] n_q   [CB];

    always_comb begin
        w_rem[0] = i_num;
        w_den[0] = i_den;
        w_q[0]   = '0;
        for (int i = 1; i < CB; i++) begin
            w_rem[i] = r_rem[i-1];
            w_den[i] = r_den[i-1];
            w_q[i]   = r_q[i-1];
        end
    end

    // Quotient is known to stay below 2^CB, so the top bit is tried first.
    always_comb begin
        for (int i = 0; i < CB; i++) begin
            logic [NW-1:0] sh;
            logic          ge;
            sh = NW'(w_den[i]) << (CB - 1 - i);
            ge = (w_rem[i] >= sh);
            n_rem[i] = ge ? (w_rem[i] - sh) : w_rem[i];
            n_q[i] = {w_q[i][CB-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < CB; i++) begin
                r_rem[i] <= n_rem[i];
                r_den[i] <= w_den[i];
                r_q[i]   <= n_q[i];
            end
        end
    end

    assign o_quo = r_q[CB-1];
endmodule
